// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define JES_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define JES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/jes_pkg.sv =====
// ----------------------------------------------------------------------------
// jes_pkg
// Types and byte constants for the JIS/EUC to Shift_JIS converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jes_pkg;

  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_SEL  = 2'd1,
    ESC_SKIP = 2'd2
  } esc_phase_e;

  typedef enum logic {
    SRC_JIS = 1'b0,
    SRC_EUC = 1'b1
  } src_enc_e;

  localparam logic [ByteW-1:0] CHR_ESC      = 8'h1B;
  localparam logic [ByteW-1:0] SEL_KANJI    = 8'h24;
  localparam logic [ByteW-1:0] SEL_ASCII    = 8'h28;
  localparam logic [ByteW-1:0] JIS_ROW_SPLIT = 8'h5F;
  localparam logic [ByteW-1:0] JIS_HI_LOW   = 8'h70;
  localparam logic [ByteW-1:0] JIS_HI_HIGH  = 8'hB0;
  localparam logic [ByteW-1:0] JIS_LO_HIGH  = 8'h20;
  localparam logic [ByteW-1:0] JIS_LO_LOW   = 8'h1F;
  localparam logic [ByteW-1:0] JIS_LO_EVEN  = 8'h7E;
  localparam logic [ByteW-1:0] EUC_LEAD_MIN = 8'hA0;
  localparam logic [ByteW-1:0] EUC_NOT_LEAD = 8'hFF;
  localparam logic [ByteW-1:0] EUC_LO_ODD   = 8'h61;
  localparam logic [ByteW-1:0] EUC_LO_WRAP  = 8'h7E;
  localparam logic [ByteW-1:0] EUC_LO_EVEN  = 8'h02;
  localparam logic [ByteW-1:0] EUC_HI_SPLIT = 8'hDF;
  localparam logic [ByteW-1:0] EUC_HI_HIGH  = 8'h70;
  localparam logic [ByteW-1:0] EUC_HI_LOW   = 8'h30;

  typedef struct packed {
    logic [1:0]       cnt;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
  } res_t;

endpackage

`default_nettype wire

// ===== design/jes_core.sv =====
// ----------------------------------------------------------------------------
// jes_core
// Decode state and byte mapping; turns one request into zero to two bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jes_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_src_i,
  input  wire logic                     fire_i,
  input  wire logic [jes_pkg::ByteW-1:0] byte_i,
  input  wire logic                     last_i,
  output jes_pkg::res_t                  res_o
);
  import jes_pkg::*;

  src_enc_e           src_q;
  logic               kanji_q, kanji_d;
  esc_phase_e         phase_q, phase_d;
  logic               pend_q, pend_d;
  logic [ByteW-1:0]   lead_q, lead_d;

  logic [ByteW:0]     lead_inc;
  logic [ByteW-1:0]   half;
  logic [ByteW-1:0]   jis_hi, jis_lo, euc_hi, euc_lo, euc_t;

  always_comb begin
    lead_inc = {1'b0, lead_q} + 9'd1;
    half     = lead_inc[ByteW:1];
    jis_hi   = half + ((lead_q < JIS_ROW_SPLIT) ? JIS_HI_LOW : JIS_HI_HIGH);
    if (lead_q[0]) begin
      jis_lo = byte_i + ((byte_i > JIS_ROW_SPLIT) ? JIS_LO_HIGH : JIS_LO_LOW);
    end else begin
      jis_lo = byte_i + JIS_LO_EVEN;
    end
    euc_t = byte_i - EUC_LO_ODD;
    if (lead_q[0]) begin
      euc_lo = (euc_t > EUC_LO_WRAP) ? euc_t + 8'd1 : euc_t;
    end else begin
      euc_lo = byte_i - EUC_LO_EVEN;
    end
    euc_hi = half + ((lead_q >= EUC_HI_SPLIT) ? EUC_HI_HIGH : EUC_HI_LOW);
  end

  always_comb begin
    kanji_d   = kanji_q;
    phase_d   = phase_q;
    pend_d    = pend_q;
    lead_d    = lead_q;
    res_o.cnt = 2'd0;
    res_o.b0  = byte_i;
    res_o.b1  = jis_lo;
    if (src_q == SRC_JIS) begin
      case (phase_q)
        ESC_SEL: begin
          if (byte_i == SEL_KANJI) begin
            kanji_d = 1'b1;
          end else if (byte_i == SEL_ASCII) begin
            kanji_d = 1'b0;
          end
          phase_d = ESC_SKIP;
        end
        ESC_NONE: begin
          if (pend_q) begin
            res_o.cnt = 2'd2;
            res_o.b0  = jis_hi;
            res_o.b1  = jis_lo;
            pend_d    = 1'b0;
          end else if (byte_i == CHR_ESC) begin
            phase_d = ESC_SEL;
          end else if (kanji_q) begin
            lead_d = byte_i;
            pend_d = 1'b1;
          end else begin
            res_o.cnt = 2'd1;
          end
        end
        default: begin
          phase_d = ESC_NONE;
        end
      endcase
    end else begin
      if (pend_q) begin
        res_o.cnt = 2'd2;
        res_o.b0  = euc_hi;
        res_o.b1  = euc_lo;
        pend_d    = 1'b0;
      end else if (byte_i <= EUC_LEAD_MIN || byte_i == EUC_NOT_LEAD || last_i) begin
        res_o.cnt = 2'd1;
      end else begin
        lead_d = byte_i;
        pend_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= SRC_JIS;
      kanji_q <= 1'b0;
      phase_q <= ESC_NONE;
      pend_q  <= 1'b0;
      lead_q  <= '0;
    end else if (cfg_we_i) begin
      src_q   <= src_enc_e'(cfg_src_i);
      kanji_q <= 1'b0;
      phase_q <= ESC_NONE;
      pend_q  <= 1'b0;
      lead_q  <= '0;
    end else if (fire_i) begin
      if (last_i) begin
        kanji_q <= 1'b0;
        phase_q <= ESC_NONE;
        pend_q  <= 1'b0;
        lead_q  <= '0;
      end else begin
        kanji_q <= kanji_d;
        phase_q <= phase_d;
        pend_q  <= pend_d;
        lead_q  <= lead_d;
      end
    end
  end

`include "assert_macros.svh"

  `JES_ASSERT(a_lead_not_in_escape, clk_i, rst_ni, !(pend_q && phase_q != ESC_NONE), "lead held inside escape")
  `JES_ASSERT(a_phase_valid, clk_i, rst_ni, phase_q != 2'd3, "unused escape phase reached")
  `JES_ASSERT(a_last_clears, clk_i, rst_ni, fire_i && last_i |=> !pend_q && !kanji_q && phase_q == ESC_NONE, "state kept past end of string")

endmodule

`default_nettype wire

// ===== design/jis_euc_to_shift_jis_unit.sv =====
// ----------------------------------------------------------------------------
// jis_euc_to_shift_jis_unit
// Byte stream converter from JIS or EUC-JP to Shift_JIS.
// ----------------------------------------------------------------------------
// One source byte per request; each gives zero, one or two Shift_JIS bytes,
// the final one flagged by out_last_o. A request enters an input register,
// is decoded once the result buffer has room and lands in a two-byte result
// buffer. Requests are taken one per cycle as long as each gives at most one
// byte and the output is not stalled; a kanji pair holds the result buffer
// until both of its bytes are taken, which holds back the input. Writing
// the source encoding (0 JIS, 1 EUC) also clears the string state.
`timescale 1ns / 1ps
`default_nettype none

module jis_euc_to_shift_jis_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [jes_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                      in_last_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [jes_pkg::ByteW-1:0] out_byte_o,
  output      logic                      out_last_o,
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic                      cfg_source_encoding_i
);
  import jes_pkg::*;

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  logic [1:0]       cnt_q, cnt_d;
  logic [ByteW-1:0] b0_q, b0_d, b1_q, b1_d;
  logic             l0_q, l0_d;

  logic             adv, pop;
  res_t             res;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_byte_o  = b0_q;
  assign out_last_o  = l0_q;

  assign pop        = out_valid_o && out_ready_i;
  assign adv        = in_vld_q && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i));
  assign in_ready_o = !in_vld_q || adv;

  jes_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_src_i (cfg_source_encoding_i),
    .fire_i    (adv),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .res_o     (res)
  );

  always_comb begin
    cnt_d = cnt_q;
    b0_d  = b0_q;
    b1_d  = b1_q;
    l0_d  = l0_q;
    if (adv) begin
      cnt_d = res.cnt;
      b0_d  = res.b0;
      b1_d  = res.b1;
      l0_d  = (res.cnt == 2'd1);
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      b0_d  = b1_q;
      l0_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    b0_q <= b0_d;
    b1_q <= b1_d;
    l0_q <= l0_d;
  end

`include "assert_macros.svh"

  `JES_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "result buffer overfilled")
  `JES_ASSERT(a_stall_holds_item, clk_i, rst_ni, !in_ready_o |-> in_vld_q, "input stalled with empty register")
  `JES_ASSERT(a_pair_tail_last, clk_i, rst_ni, cnt_q == 2'd2 |-> !l0_q, "first byte of pair flagged last")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JIS/EUC-JP to Shift_JIS byte converter.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes opens the run. Where the converted bytes
// are obvious they are typed into the table. Random strings follow, mostly
// well-formed escapes, kanji pairs and EUC pairs with some noise mixed in,
// under both source encodings. Every accepted request runs through a local
// converter model, and each output byte is matched against the oldest
// pending expected byte. The sender works in bursts, and the receiver
// stalls on patterns of its own.
`timescale 1ns / 1ps

module testbench;
  import jes_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sjis_byte_t;

  typedef struct packed {
    logic       set_cfg;
    logic       cfg_val;
    logic [7:0] b;
    logic       last;
    logic       fixed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
  } dir_row_t;

  localparam int NumDirected = 29;
  localparam dir_row_t DIRECTED [NumDirected] = '{
    '{1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, 2'd1, 8'hFF, 8'h00},
    '{1'b0, 1'b0, 8'h1B, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h24, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h42, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b1, 2'd2, 8'h30, 8'h1F},
    '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h1B, 1'b0, 1'b1, 2'd2, 8'h70, 8'h99},
    '{1'b0, 1'b0, 8'h1B, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h1B, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h1B, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h5E, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h60, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h21, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h1B, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h28, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h42, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h41, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00},
    '{1'b0, 1'b0, 8'h1B, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b1, 1'b1, 8'hA1, 1'b1, 1'b1, 2'd1, 8'hA1, 8'h00},
    '{1'b0, 1'b0, 8'hA0, 1'b0, 1'b1, 2'd1, 8'hA0, 8'h00},
    '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00},
    '{1'b0, 1'b0, 8'hA1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'hA1, 1'b0, 1'b1, 2'd2, 8'h81, 8'h40},
    '{1'b0, 1'b0, 8'hFE, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'hFE, 1'b0, 1'b1, 2'd2, 8'hEF, 8'hFC},
    '{1'b0, 1'b0, 8'hDF, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_enc = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       cfg_ready_o;

  jis_euc_to_shift_jis_unit dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .in_byte_i             (in_byte),
    .in_last_i             (in_last),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .out_byte_o            (out_byte_o),
    .out_last_o            (out_last_o),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_source_encoding_i (cfg_enc)
  );

  // converter model state
  src_enc_e   src_enc = SRC_JIS;
  logic       kanji_on = 1'b0;
  esc_phase_e esc_state = ESC_NONE;
  logic       lead_held = 1'b0;
  logic [7:0] lead_val = 8'h00;

  sjis_byte_t sjis_expected [$];
  sjis_byte_t oldest_byte;
  int         mismatch_count = 0;

  int   burst_left = 0;
  logic gap_enable = 1'b1;
  logic rx_hold_req = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
  endtask

  function automatic void clear_string_state();
    kanji_on  = 1'b0;
    esc_state = ESC_NONE;
    lead_held = 1'b0;
    lead_val  = 8'h00;
  endfunction

  // Returns how many Shift_JIS bytes the source byte yields, in r0 then r1.
  function automatic int convert_byte(input logic [7:0] b, input logic last,
                                      output logic [7:0] r0, output logic [7:0] r1);
    int         n;
    logic [8:0] half;
    logic [7:0] c1;
    n  = 0;
    r0 = 8'h00;
    r1 = 8'h00;
    half = ({1'b0, lead_val} + 9'd1) >> 1;
    if (src_enc == SRC_JIS) begin
      if (esc_state == ESC_SEL) begin
        if (b == SEL_KANJI) kanji_on = 1'b1;
        else if (b == SEL_ASCII) kanji_on = 1'b0;
        esc_state = ESC_SKIP;
      end else if (esc_state != ESC_NONE) begin
        esc_state = ESC_NONE;
      end else if (lead_held) begin
        r0 = half[7:0] + ((lead_val < JIS_ROW_SPLIT) ? JIS_HI_LOW : JIS_HI_HIGH);
        if (lead_val[0]) r1 = b + ((b > JIS_ROW_SPLIT) ? JIS_LO_HIGH : JIS_LO_LOW);
        else r1 = b + JIS_LO_EVEN;
        n = 2;
        lead_held = 1'b0;
      end else if (b == CHR_ESC) begin
        esc_state = ESC_SEL;
      end else if (kanji_on) begin
        lead_val  = b;
        lead_held = 1'b1;
      end else begin
        r0 = b;
        n  = 1;
      end
    end else begin
      if (lead_held) begin
        if (lead_val[0]) begin
          c1 = b - EUC_LO_ODD;
          if (c1 > EUC_LO_WRAP) c1 = c1 + 8'd1;
        end else begin
          c1 = b - EUC_LO_EVEN;
        end
        r0 = half[7:0] + ((lead_val >= EUC_HI_SPLIT) ? EUC_HI_HIGH : EUC_HI_LOW);
        r1 = c1;
        n  = 2;
        lead_held = 1'b0;
      end else if (b <= EUC_LEAD_MIN || b == EUC_NOT_LEAD || last) begin
        r0 = b;
        n  = 1;
      end else begin
        lead_val  = b;
        lead_held = 1'b1;
      end
    end
    if (last) clear_string_state();
    return n;
  endfunction

  task automatic push_expected(input int n, input logic [7:0] r0, input logic [7:0] r1);
    if (n == 1) begin
      sjis_expected.insert(sjis_expected.size(), sjis_byte_t'{r0, 1'b1});
    end else if (n == 2) begin
      sjis_expected.insert(sjis_expected.size(), sjis_byte_t'{r0, 1'b0});
      sjis_expected.insert(sjis_expected.size(), sjis_byte_t'{r1, 1'b1});
    end
  endtask

  task automatic append_text(ref logic [7:0] text_q [$], input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic sender_idle(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sjis_expected.size() != 0) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, output int n,
                           output logic [7:0] r0, output logic [7:0] r1);
    @(negedge clk);
    in_valid = 1'b1;
    in_byte  = b;
    in_last  = last;
    do @(posedge clk); while (!in_ready_o);
    n = convert_byte(b, last, r0, r1);
  endtask

  task automatic offer_byte(input logic [7:0] b, input logic last);
    int         n;
    logic [7:0] r0;
    logic [7:0] r1;
    if (gap_enable && burst_left == 0) begin
      sender_idle($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    send_byte(b, last, n, r0, r1);
    push_expected(n, r0, r1);
  endtask

  // Register write only with the converter idle; in-flight requests that
  // yield no byte are first let clear the pipeline.
  task automatic write_encoding(input src_enc_e enc);
    sender_idle(1);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_enc   = enc;
    do @(posedge clk); while (!cfg_ready_o);
    src_enc = enc;
    clear_string_state();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic build_string(input src_enc_e enc, ref logic [7:0] text_q [$]);
    int target;
    int pick;
    text_q.delete();
    target = $urandom_range(1, 20);
    while (text_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (enc == SRC_JIS) begin
        if (pick < 30) begin
          append_text(text_q, 8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 45) begin
          append_text(text_q, CHR_ESC);
          append_text(text_q, SEL_KANJI);
          append_text(text_q, 8'($urandom_range(0, 255)));
        end else if (pick < 55) begin
          append_text(text_q, CHR_ESC);
          append_text(text_q, SEL_ASCII);
          append_text(text_q, 8'($urandom_range(0, 255)));
        end else if (pick < 80) begin
          if ($urandom_range(0, 9) < 7) begin
            append_text(text_q, 8'($urandom_range(8'h21, 8'h7E)));
            append_text(text_q, 8'($urandom_range(8'h21, 8'h7E)));
          end else begin
            append_text(text_q, 8'($urandom_range(0, 255)));
            append_text(text_q, 8'($urandom_range(0, 255)));
          end
        end else if (pick < 90) begin
          append_text(text_q, 8'($urandom_range(0, 255)));
        end else begin
          append_text(text_q, CHR_ESC);
          append_text(text_q, 8'($urandom_range(0, 255)));
          append_text(text_q, 8'($urandom_range(0, 255)));
        end
      end else begin
        if (pick < 35) begin
          append_text(text_q, 8'($urandom_range(0, 8'hA0)));
        end else if (pick < 80) begin
          append_text(text_q, 8'($urandom_range(8'hA1, 8'hFE)));
          if ($urandom_range(0, 9) < 8) begin
            append_text(text_q, 8'($urandom_range(8'hA1, 8'hFE)));
          end else begin
            append_text(text_q, 8'($urandom_range(0, 255)));
          end
        end else if (pick < 90) begin
          append_text(text_q, ($urandom_range(0, 1) != 0) ? EUC_NOT_LEAD : 8'($urandom));
        end else begin
          append_text(text_q, 8'($urandom_range(8'hA1, 8'hFE)));
        end
      end
    end
    while (text_q.size() > target) void'(text_q.pop_back());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (sjis_expected.size() == 0) begin
        report_mismatch("byte with nothing pending", out_byte_o, 8'h00);
      end else begin
        oldest_byte = sjis_expected.pop_front();
        if (out_byte_o !== oldest_byte.data) begin
          report_mismatch("out_byte", out_byte_o, oldest_byte.data);
        end
        if (out_last_o !== oldest_byte.last) begin
          report_mismatch("out_last", {7'd0, out_last_o}, {7'd0, oldest_byte.last});
        end
      end
    end
  end

  // receiver: stall pattern changes every so often; long hold-off on request
  initial begin
    int hold_left;
    int rx_mode;
    int rx_tick;
    hold_left = 0;
    rx_mode   = 0;
    rx_tick   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left   = 400;
        rx_hold_req = 1'b0;
      end
      if (rx_tick == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_tick = $urandom_range(20, 120);
      end
      rx_tick--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ((rx_tick % 4) == 0);
          default: out_ready = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    dir_row_t   row;
    int         n;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] text_q [$];
    int         sent;
    logic       paused;
    src_enc_e   enc;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      row = DIRECTED[i];
      if (row.set_cfg) write_encoding(src_enc_e'(row.cfg_val));
      send_byte(row.b, row.last, n, r0, r1);
      if (row.fixed) push_expected(int'(row.n), row.e0, row.e1);
      else push_expected(n, r0, r1);
    end

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) enc = SRC_JIS;
      else if (phase == 1) enc = SRC_EUC;
      else enc = src_enc_e'($urandom_range(0, 1));
      write_encoding(enc);
      if (phase == 3) rx_hold_req = 1'b1;
      sent   = 0;
      paused = 1'b0;
      while (sent < 250) begin
        build_string(enc, text_q);
        foreach (text_q[k]) begin
          gap_enable = !(phase == 5 || (phase == 3 && sent < 100));
          offer_byte(text_q[k], k == text_q.size() - 1);
          sent++;
        end
        if (phase == 4 && !paused && sent >= 120) begin
          sender_idle(1);
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    sender_idle(1);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
